// ===== hw/rtl/pse_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pse_pkg
// Shared types and codes for the postfix stack evaluator.
// ---------------------------------------------------------------------------
package pse_pkg;

  localparam int DATA_W  = 32;  // Q16.16 word
  localparam int OP_W    = 3;
  localparam int DEPTH_W = 8;   // depth field on the result channel
  localparam int ST_W    = 3;
  localparam int ALU_W   = DATA_W + 2;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam int IN_TDATA_W  = 40;  // value + start_req, padded to bytes
  localparam int OUT_TDATA_W = 40;  // top_value + depth

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ALU_W-1:0] alu_word_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_UNDER = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_DIVZ  = 3'd3;
  localparam status_t ST_SAT   = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/pse_alu.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pse_alu
// Shared adder/subtractor; the add/subtract, multiply, divide and rounding steps use it.
// ---------------------------------------------------------------------------
module pse_alu (
  input  wire pse_pkg::alu_word_t a,
  input  wire pse_pkg::alu_word_t b,
  input  wire                     sub,
  output pse_pkg::alu_word_t      y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

// ===== hw/rtl/postfix_stack_evaluator_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Reverse-Polish evaluator over a stack of signed Q16.16 values.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser
//  in_     | in  | [31:0] value, [32] start_req  | [2:0] op
//  out_    | out | [31:0] top_value, [39:32] depth | [2:0] status
//
// Push, unknown op, error and add/subtract tokens finish without iterating.
// Multiply and divide iterate: 32 passes through the one shared 34-bit adder
// (shift-add multiply, restoring divide); a divide whose quotient would reach
// 2^32 or more skips the passes and saturates.
// Reset (rst_n low, synchronous) empties the stack; no clearing pass.
// in_tready is high only while idle. A finished result waits in the output
// register, so a new transaction is taken while out_tready is low.
// ---------------------------------------------------------------------------
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = 128,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in: [31:0] value, [32] start_req, [39:33] zero
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [pse_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in: [2:0] op
  input  wire  pse_pkg::op_t                  in_tuser,
  // out: [31:0] top_value, [39:32] depth
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [pse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out: [2:0] status
  output pse_pkg::status_t                    out_tuser
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DW  = pse_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_MFIX, S_DCHK, S_DIV, S_RND, S_RES, S_FIN
  } state_t;

  state_t              state_r;
  logic [SPW-1:0]      sp_r;
  pse_pkg::op_t        op_r;
  pse_pkg::word_t      val_r;

  // stack storage, two registered read ports and one write port
  pse_pkg::word_t      mem [STACK_DEPTH];
  pse_pkg::word_t      rd_t_r, rd_s_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  pse_pkg::word_t      mem_wdata;
  logic [AW-1:0]       addr_t, addr_s;

  // iteration registers: hi/lo hold the product, or remainder/dividend
  pse_pkg::word_t      ms_r, mt_r, hi_r, lo_r;
  logic                neg_r, inc_r, big_r;
  logic [DW:0]         mag_r;
  logic [pse_pkg::CNT_W-1:0] cnt_r;

  pse_pkg::word_t      res_top_r;
  pse_pkg::status_t    res_st_r;
  logic                out_valid_r;
  logic [pse_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  pse_pkg::status_t    out_tuser_r;

  pse_pkg::alu_word_t  alu_a, alu_b, alu_y;
  logic                alu_sub;

  pse_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

  assign addr_t = AW'(sp_r - SPW'(1));
  assign addr_s = AW'(sp_r - SPW'(2));

  // top of stack when the token leaves the stack unchanged
  pse_pkg::word_t keep_top;
  assign keep_top = (sp_r != '0) ? rd_t_r : '0;

  // magnitudes; the most negative value maps to 2^31 in 32 unsigned bits
  pse_pkg::word_t mag_s, mag_t;
  assign mag_s = rd_s_r[DW-1] ? (~rd_s_r + 1'b1) : rd_s_r;
  assign mag_t = rd_t_r[DW-1] ? (~rd_t_r + 1'b1) : rd_t_r;

  // fixed-point dividend ms << FRAC_BITS, split into halves
  logic [2*DW-1:0] dvd;
  assign dvd = (2*DW)'(ms_r) << FRAC_BITS;

  // product post-processing: floor shift for negative results
  logic [2*DW-1:0] prod, prod_q, frac_mask;
  logic            prod_rem_nz;
  assign prod        = {hi_r, lo_r};
  assign prod_q      = prod >> FRAC_BITS;
  assign frac_mask   = ((2*DW)'(1) << FRAC_BITS) - (2*DW)'(1);
  assign prod_rem_nz = |(prod & frac_mask);

  // add/sub saturation: 33-bit exact result in a 34-bit adder
  logic            as_sat;
  pse_pkg::word_t  as_val;
  assign as_sat = alu_y[DW] != alu_y[DW-1];
  assign as_val = as_sat ? (alu_y[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                         : alu_y[DW-1:0];

  // sign-magnitude to two's complement with saturation
  logic            rs_sat;
  pse_pkg::word_t  rs_val;
  always_comb begin
    if (neg_r) begin
      rs_sat = big_r || (mag_r > {2'b01, {(DW-1){1'b0}}});
      rs_val = rs_sat ? {1'b1, {(DW-1){1'b0}}} : (~mag_r[DW-1:0] + 1'b1);
    end else begin
      rs_sat = big_r || mag_r[DW] || mag_r[DW-1];
      rs_val = rs_sat ? {1'b0, {(DW-1){1'b1}}} : mag_r[DW-1:0];
    end
  end

  // restoring-divide step
  logic            div_fit;
  pse_pkg::word_t  div_rem, div_q;
  assign div_fit = !alu_y[pse_pkg::ALU_W-1];
  assign div_rem = div_fit ? alu_y[DW-1:0] : {hi_r[DW-2:0], lo_r[DW-1]};
  assign div_q   = {lo_r[DW-2:0], div_fit};

  logic is_arith, has_two, is_full;
  assign is_arith = (op_r == pse_pkg::OP_ADD) || (op_r == pse_pkg::OP_SUB);
  assign has_two  = sp_r >= SPW'(2);
  assign is_full  = sp_r >= SPW'(STACK_DEPTH);

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        alu_a   = {{2{rd_s_r[DW-1]}}, rd_s_r};
        alu_b   = {{2{rd_t_r[DW-1]}}, rd_t_r};
        alu_sub = (op_r == pse_pkg::OP_SUB);
      end
      S_MUL: begin
        alu_a = {2'b00, hi_r};
        alu_b = lo_r[0] ? {2'b00, mt_r} : '0;
      end
      S_DCHK: begin
        alu_a   = {2'b00, dvd[2*DW-1:DW]};
        alu_b   = {2'b00, mt_r};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {1'b0, hi_r, lo_r[DW-1]};
        alu_b   = {2'b00, mt_r};
        alu_sub = 1'b1;
      end
      S_RND: begin
        alu_a = {1'b0, mag_r};
        alu_b = pse_pkg::ALU_W'(inc_r);
      end
      default: ;
    endcase
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_s;
    mem_wdata = rs_val;
    if (state_r == S_EXEC) begin
      if (op_r == pse_pkg::OP_PUSH && !is_full) begin
        mem_we    = 1'b1;
        mem_waddr = AW'(sp_r);
        mem_wdata = val_r;
      end else if (is_arith && has_two) begin
        mem_we    = 1'b1;
        mem_wdata = as_val;
      end
    end else if (state_r == S_RES) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_READ) begin
      rd_t_r <= mem[addr_t];
      rd_s_r <= mem[addr_s];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_FIN handles the output register itself
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            val_r   <= in_tdata[DW-1:0];
            if (in_tdata[DW]) begin
              sp_r <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          ms_r      <= mag_s;
          mt_r      <= mag_t;
          neg_r     <= rd_s_r[DW-1] ^ rd_t_r[DW-1];
          hi_r      <= '0;
          lo_r      <= mag_s;
          cnt_r     <= '0;
          big_r     <= 1'b0;
          inc_r     <= 1'b0;
          unique case (op_r)
            pse_pkg::OP_PUSH: begin
              state_r <= S_FIN;
              if (is_full) begin
                res_top_r <= keep_top;
                res_st_r  <= pse_pkg::ST_FULL;
              end else begin
                sp_r      <= sp_r + SPW'(1);
                res_top_r <= val_r;
                res_st_r  <= pse_pkg::ST_OK;
              end
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
              if (!has_two) begin
                res_top_r <= keep_top;
                res_st_r  <= pse_pkg::ST_UNDER;
                state_r   <= S_FIN;
              end else if (is_arith) begin
                sp_r      <= sp_r - SPW'(1);
                res_top_r <= as_val;
                res_st_r  <= as_sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
                state_r   <= S_FIN;
              end else if (op_r == pse_pkg::OP_MUL) begin
                state_r <= S_MUL;
              end else if (rd_t_r == '0) begin
                res_top_r <= keep_top;
                res_st_r  <= pse_pkg::ST_DIVZ;
                state_r   <= S_FIN;
              end else begin
                state_r <= S_DCHK;
              end
            end
            default: begin
              // unknown op: ignored
              res_top_r <= keep_top;
              res_st_r  <= pse_pkg::ST_OK;
              state_r   <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          hi_r  <= alu_y[DW:1];
          lo_r  <= {alu_y[0], lo_r[DW-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pse_pkg::CNT_W'(DW - 1)) begin
            state_r <= S_MFIX;
          end
        end
        S_MFIX: begin
          mag_r   <= prod_q[DW:0];
          big_r   <= |prod_q[2*DW-1:DW+1];
          inc_r   <= neg_r && prod_rem_nz;
          neg_r   <= neg_r && (prod != '0);
          state_r <= S_RND;
        end
        S_DCHK: begin
          if (!alu_y[pse_pkg::ALU_W-1]) begin
            // quotient of 2^32 or more
            big_r   <= 1'b1;
            mag_r   <= '0;
            state_r <= S_RES;
          end else begin
            hi_r    <= dvd[2*DW-1:DW];
            lo_r    <= dvd[DW-1:0];
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          hi_r  <= div_rem;
          lo_r  <= div_q;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pse_pkg::CNT_W'(DW - 1)) begin
            mag_r   <= {1'b0, div_q};
            neg_r   <= neg_r && (div_q != '0);
            state_r <= S_RND;
          end
        end
        S_RND: begin
          mag_r   <= alu_y[DW:0];
          big_r   <= big_r || alu_y[DW+1];
          state_r <= S_RES;
        end
        S_RES: begin
          sp_r      <= sp_r - SPW'(1);
          res_top_r <= rs_val;
          res_st_r  <= rs_sat ? pse_pkg::ST_SAT : pse_pkg::ST_OK;
          state_r   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tdata_r <= {pse_pkg::DEPTH_W'(sp_r), res_top_r};
            out_tuser_r <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pse_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator.
// ---------------------------------------------------------------------------
module pse_checker #(
  parameter int STACK_DEPTH = 128
) (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tvalid,
  input wire                                 in_tready,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [pse_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input wire pse_pkg::status_t               out_tuser
);

  localparam bit DEPTH_FITS = STACK_DEPTH < 256;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one token at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  a_under_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && DEPTH_FITS && out_tuser == pse_pkg::ST_UNDER |-> out_tdata[39:32] < 8'd2)
    else $error("underflow with two or more values");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pse_pkg::ST_FULL |-> out_tdata[39:32] == 8'(STACK_DEPTH))
    else $error("full status below capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && DEPTH_FITS && out_tdata[39:32] == 8'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero top on empty stack");

endmodule

bind postfix_stack_evaluator_top pse_checker #(.STACK_DEPTH(STACK_DEPTH)) u_pse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
